// ===== rtl/ipct_pkg.sv =====
`default_nettype none

package ipct_pkg;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] hits;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RESP,
        S_HDR,
        S_DUMP,
        S_SPIN
    } state_t;

    localparam logic [1:0] KIND_OBSERVE = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ENTRY   = 2'd2;

    localparam logic [1:0] STAT_EXISTING = 2'd0;
    localparam logic [1:0] STAT_NEW      = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_ZERO     = 2'd3;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_DUMP    = 1'b1;

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ipct_cell.sv =====
`default_nettype none

module ipct_cell
    import ipct_pkg::*;
(
    input  wire    aclk,
    input  wire    shift_en,
    input  entry_t d_in,
    output entry_t q
);

    entry_t q_reg;

    // Each cell holds one table entry and takes its neighbor's entry on a shift.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ===== rtl/ip_address_count_table.sv =====
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_opcode, s_ip_addr
// m_       out        m_valid/m_ready    m_kind, m_status, m_total_seen, m_unique_seen,
//                                        m_entry_addr, m_entry_hits, m_last
//
// The entries sit in a ring of TABLE_DEPTH cells that shifts toward cell 0. An
// observe request with a nonzero address rotates the ring once; a zero address or
// an empty dump leaves the ring still. A dump emits a header and then one entry
// per cycle, followed by the rest of the rotation. A stall on m_ready holds the
// ring during the dump. Reset empties the table at once.

module ip_address_count_table
    import ipct_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [31:0] s_ip_addr,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_status,
    output logic [31:0] m_total_seen,
    output logic [5:0]  m_unique_seen,
    output logic [31:0] m_entry_addr,
    output logic [31:0] m_entry_hits,
    output logic        m_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [KW-1:0] K_END = KW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [31:0]   ip_reg, ip_next;
    logic [1:0]    status_reg, status_next;
    logic [KW-1:0] k_reg, k_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   total_reg, total_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_kind_reg, m_kind_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [31:0]   m_total_reg, m_total_next;
    logic [5:0]    m_unique_reg, m_unique_next;
    logic [31:0]   m_addr_reg, m_addr_next;
    logic [31:0]   m_hits_reg, m_hits_next;
    logic          m_last_reg, m_last_next;

    entry_t        cell_q [TABLE_DEPTH];
    entry_t        feed;
    entry_t        head;
    logic          rotate;
    logic          out_free;
    logic          in_acc;
    logic          match;
    logic          append_now;
    logic [CW-1:0] k_ext;
    logic          k_at_end;
    logic          k_at_last_entry;

    // Ring of cells: cell i takes from cell i+1, the far end takes the fed entry.
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            entry_t cell_d;
            if (gi == TABLE_DEPTH - 1) begin : g_end
                assign cell_d = feed;
            end else begin : g_mid
                assign cell_d = cell_q[gi+1];
            end
            ipct_cell u_cell (
                .aclk     (aclk),
                .shift_en (rotate),
                .d_in     (cell_d),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign head     = cell_q[0];
    assign out_free = !m_valid_reg || m_ready;
    assign in_acc   = s_valid && s_ready;
    assign k_ext    = CW'(k_reg);
    assign k_at_end = (k_reg == K_END);
    assign k_at_last_entry = (k_ext == fill_reg - CW'(1));

    // The entry at cell 0 during step k of a rotation is entry k.
    assign match      = (state_reg == S_SEARCH) && (k_ext < fill_reg)
                        && (head.addr == ip_reg) && (status_reg == STAT_FULL);
    assign append_now = (state_reg == S_SEARCH) && (k_ext == fill_reg)
                        && (fill_reg < FILL_MAX) && (status_reg == STAT_FULL);

    always_comb begin
        feed = head;
        if (match) begin
            feed.hits = sat_inc(head.hits);
        end else if (append_now) begin
            feed.addr = ip_reg;
            feed.hits = 32'd1;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_opcode == OP_DUMP) begin
                        state_next = S_HDR;
                    end else if (s_ip_addr == 32'd0) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (k_at_end) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_HDR: begin
                if (out_free) begin
                    state_next = (fill_reg == '0) ? S_IDLE : S_DUMP;
                end
            end
            S_DUMP: begin
                if (out_free && k_at_last_entry) begin
                    state_next = k_at_end ? S_IDLE : S_SPIN;
                end
            end
            S_SPIN: begin
                if (k_at_end) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result register control.
    always_comb begin
        s_ready       = 1'b0;
        rotate        = 1'b0;
        ip_next       = ip_reg;
        status_next   = status_reg;
        k_next        = k_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_status_next = m_status_reg;
        m_total_next  = m_total_reg;
        m_unique_next = m_unique_reg;
        m_addr_next   = m_addr_reg;
        m_hits_next   = m_hits_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (in_acc) begin
                    ip_next = s_ip_addr;
                    k_next  = '0;
                    if (s_opcode == OP_OBSERVE) begin
                        if (s_ip_addr == 32'd0) begin
                            status_next = STAT_ZERO;
                        end else begin
                            status_next = STAT_FULL;
                            total_next  = sat_inc(total_reg);
                        end
                    end
                end
            end
            S_SEARCH: begin
                rotate = 1'b1;
                k_next = k_reg + KW'(1);
                if (match) begin
                    status_next = STAT_EXISTING;
                end else if (append_now) begin
                    status_next = STAT_NEW;
                end
                if (k_at_end && ((status_reg == STAT_NEW) || append_now)) begin
                    fill_next = fill_reg + CW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_OBSERVE;
                    m_status_next = status_reg;
                    m_total_next  = total_reg;
                    m_unique_next = 6'(fill_reg);
                    m_addr_next   = 32'd0;
                    m_hits_next   = 32'd0;
                    m_last_next   = 1'b1;
                end
            end
            S_HDR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_HEADER;
                    m_status_next = STAT_EXISTING;
                    m_total_next  = total_reg;
                    m_unique_next = 6'(fill_reg);
                    m_addr_next   = 32'd0;
                    m_hits_next   = 32'd0;
                    m_last_next   = (fill_reg == '0);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    rotate        = 1'b1;
                    k_next        = k_reg + KW'(1);
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_ENTRY;
                    m_status_next = STAT_EXISTING;
                    m_total_next  = total_reg;
                    m_unique_next = 6'(fill_reg);
                    m_addr_next   = head.addr;
                    m_hits_next   = head.hits;
                    m_last_next   = k_at_last_entry;
                end
            end
            S_SPIN: begin
                // Finish the rotation so the entries return to their places.
                rotate = 1'b1;
                k_next = k_reg + KW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            total_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg       <= ip_next;
        status_reg   <= status_next;
        k_reg        <= k_next;
        m_kind_reg   <= m_kind_next;
        m_status_reg <= m_status_next;
        m_total_reg  <= m_total_next;
        m_unique_reg <= m_unique_next;
        m_addr_reg   <= m_addr_next;
        m_hits_reg   <= m_hits_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_status      = m_status_reg;
    assign m_total_seen  = m_total_reg;
    assign m_unique_seen = m_unique_reg;
    assign m_entry_addr  = m_addr_reg;
    assign m_entry_hits  = m_hits_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire
